/* sv/i2crts_pkg.sv */
// Shared types and constants for the I2C register transaction sequencer.
package i2crts_pkg;

  // Largest read length accepted on a begin transfer; longer counts are clamped.
  localparam logic [7:0] MaxReadBytes = 8'd255;

  // Bit positions inside event_flags.
  localparam int unsigned FlagStartBit = 0;
  localparam int unsigned FlagAddrBit  = 1;
  localparam int unsigned FlagTxeBit   = 2;
  localparam int unsigned FlagRxneBit  = 3;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_ERROR = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_SEND        = 4'd1,
    ACT_START       = 4'd2,
    ACT_STOP        = 4'd3,
    ACT_ACK_ON      = 4'd4,
    ACT_ACKOFF_STOP = 4'd5,
    ACT_ACK_OFF     = 4'd6,
    ACT_REINIT      = 4'd7,
    ACT_STOP_START  = 4'd8
  } action_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       xfer_mode;
    logic [7:0] dev_addr_write;
    logic [7:0] dev_addr_read;
    logic [7:0] sub_addr;
    logic [7:0] tx_data;
    logic [7:0] rx_count;
    logic [3:0] event_flags;
    logic [7:0] rx_byte;
    logic       restart_error;
  } req_item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte_out;
    logic [7:0] rx_index;
    logic       done_res;
  } res_item_t;

endpackage

/* sv/i2crts_in_stage.sv */
// Input register stage: holds one request until the sequencer core takes it.
module i2crts_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2crts_pkg::req_item_t in_data,
  input  logic                 take,
  output logic                 held_valid,
  output i2crts_pkg::req_item_t held_item
);

  // A new transfer is taken when the stage is empty or its item leaves now.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_data;
    end
  end

endmodule

/* sv/i2crts_core.sv */
// Sequencer core: transaction state registers and the per-request step logic.
module i2crts_core #(
  parameter logic [7:0] MaxReadBytes = i2crts_pkg::MaxReadBytes
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  i2crts_pkg::req_item_t item,
  output i2crts_pkg::res_item_t res
);

  i2crts_pkg::phase_t phase, phase_next;
  logic [2:0] step_count, step_count_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] held_addr_write, held_addr_write_next;
  logic [7:0] held_addr_read, held_addr_read_next;
  logic [7:0] held_sub_addr, held_sub_addr_next;
  logic [7:0] held_tx_data, held_tx_data_next;
  logic [7:0] held_rx_count, held_rx_count_next;

  logic       st, ad, tx, rx;
  logic [7:0] cnt_clamped;
  logic [7:0] last_index;
  logic [7:0] second_last_index;

  assign st = item.event_flags[i2crts_pkg::FlagStartBit];
  assign ad = item.event_flags[i2crts_pkg::FlagAddrBit];
  assign tx = item.event_flags[i2crts_pkg::FlagTxeBit];
  assign rx = item.event_flags[i2crts_pkg::FlagRxneBit];

  assign last_index        = held_rx_count - 8'd1;
  assign second_last_index = held_rx_count - 8'd2;

  always_comb begin
    if (item.rx_count == 8'd0) begin
      cnt_clamped = 8'd1;
    end else if (item.rx_count > MaxReadBytes) begin
      cnt_clamped = MaxReadBytes;
    end else begin
      cnt_clamped = item.rx_count;
    end
  end

  always_comb begin
    phase_next           = phase;
    step_count_next      = step_count;
    byte_index_next      = byte_index;
    held_addr_write_next = held_addr_write;
    held_addr_read_next  = held_addr_read;
    held_sub_addr_next   = held_sub_addr;
    held_tx_data_next    = held_tx_data;
    held_rx_count_next   = held_rx_count;
    res                  = '0;
    res.action           = i2crts_pkg::ACT_NONE;

    unique case (item.req_type)
      i2crts_pkg::REQ_BEGIN: begin
        // A begin while a transaction is running is dropped.
        if (phase == i2crts_pkg::PH_DONE) begin
          held_addr_write_next = item.dev_addr_write;
          held_addr_read_next  = item.dev_addr_read;
          held_sub_addr_next   = item.sub_addr;
          held_tx_data_next    = item.tx_data;
          held_rx_count_next   = cnt_clamped;
          phase_next           = item.xfer_mode ? i2crts_pkg::PH_RECV : i2crts_pkg::PH_SEND;
          step_count_next      = 3'd0;
          byte_index_next      = 8'd0;
          res.action           = i2crts_pkg::ACT_START;
        end
      end
      i2crts_pkg::REQ_EVENT: begin
        unique case (phase)
          i2crts_pkg::PH_DONE: begin
            res.action = i2crts_pkg::ACT_REINIT;
          end
          i2crts_pkg::PH_SEND: begin
            priority if (st && step_count == 3'd0) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.tx_byte     = held_addr_write;
              step_count_next = 3'd1;
            end else if (tx && step_count == 3'd1) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.tx_byte     = held_sub_addr;
              step_count_next = 3'd2;
            end else if (tx && step_count == 3'd2) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.tx_byte     = held_tx_data;
              step_count_next = 3'd3;
            end else if (step_count == 3'd3) begin
              res.action      = i2crts_pkg::ACT_STOP;
              res.done_res    = 1'b1;
              phase_next      = i2crts_pkg::PH_DONE;
              step_count_next = 3'd0;
            end else begin
              res.action = i2crts_pkg::ACT_NONE;
            end
          end
          i2crts_pkg::PH_RECV: begin
            priority if (st && step_count == 3'd0) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.tx_byte     = held_addr_write;
              step_count_next = 3'd1;
            end else if (tx && step_count == 3'd1) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.tx_byte     = held_sub_addr;
              step_count_next = 3'd2;
            end else if (tx && step_count == 3'd2) begin
              res.action      = i2crts_pkg::ACT_START;
              step_count_next = 3'd3;
            end else if (tx && step_count == 3'd3) begin
              res.action      = i2crts_pkg::ACT_SEND;
              res.tx_byte     = held_addr_read;
              step_count_next = 3'd4;
            end else if (ad && step_count == 3'd4) begin
              step_count_next = 3'd5;
              res.action      = (held_rx_count == 8'd1) ? i2crts_pkg::ACT_ACKOFF_STOP
                                                         : i2crts_pkg::ACT_ACK_ON;
            end else if (rx) begin
              // A received byte is taken as data whatever step the address phase is in.
              if (held_rx_count == 8'd1) begin
                res.rx_valid    = 1'b1;
                res.rx_byte_out = item.rx_byte;
                res.action      = i2crts_pkg::ACT_STOP;
                res.done_res    = 1'b1;
                phase_next      = i2crts_pkg::PH_DONE;
                step_count_next = 3'd0;
              end else if (byte_index < held_rx_count) begin
                res.rx_valid    = 1'b1;
                res.rx_byte_out = item.rx_byte;
                res.rx_index    = byte_index;
                if (byte_index == second_last_index) begin
                  res.action      = i2crts_pkg::ACT_ACK_OFF;
                  byte_index_next = byte_index + 8'd1;
                end else if (byte_index == last_index) begin
                  res.action      = i2crts_pkg::ACT_STOP;
                  res.done_res    = 1'b1;
                  phase_next      = i2crts_pkg::PH_DONE;
                  step_count_next = 3'd0;
                  byte_index_next = 8'd0;
                end else begin
                  byte_index_next = byte_index + 8'd1;
                end
              end
            end else begin
              res.action = i2crts_pkg::ACT_NONE;
            end
          end
          default: begin
            res.action = i2crts_pkg::ACT_NONE;
          end
        endcase
      end
      i2crts_pkg::REQ_ERROR: begin
        // Bus or arbitration errors restart from the top; an acknowledge failure only stops.
        if (item.restart_error) begin
          step_count_next = 3'd0;
          byte_index_next = 8'd0;
          res.action      = i2crts_pkg::ACT_STOP_START;
        end else begin
          res.action = i2crts_pkg::ACT_STOP;
        end
      end
      default: begin
        res.action = i2crts_pkg::ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2crts_pkg::PH_DONE;
      step_count      <= 3'd0;
      byte_index      <= 8'd0;
      held_addr_write <= 8'd0;
      held_addr_read  <= 8'd0;
      held_sub_addr   <= 8'd0;
      held_tx_data    <= 8'd0;
      held_rx_count   <= 8'd1;
    end else if (fire) begin
      phase           <= phase_next;
      step_count      <= step_count_next;
      byte_index      <= byte_index_next;
      held_addr_write <= held_addr_write_next;
      held_addr_read  <= held_addr_read_next;
      held_sub_addr   <= held_sub_addr_next;
      held_tx_data    <= held_tx_data_next;
      held_rx_count   <= held_rx_count_next;
    end
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> phase == i2crts_pkg::PH_DONE)
    else $error("completed transaction did not return to idle");

  a_rx_only_receiving: assert property (@(posedge clk) disable iff (rst)
    fire && res.rx_valid |-> phase == i2crts_pkg::PH_RECV)
    else $error("received byte delivered outside a read");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == i2crts_pkg::PH_RECV |-> byte_index < held_rx_count)
    else $error("read byte index reached the read length");

  a_send_steps: assert property (@(posedge clk) disable iff (rst)
    phase == i2crts_pkg::PH_SEND |-> step_count <= 3'd3)
    else $error("write sequence step out of range");
`endif

endmodule

/* sv/i2crts_out_stage.sv */
// Result register: holds one result until the consumer takes it.
module i2crts_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  i2crts_pkg::res_item_t res,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2crts_pkg::res_item_t out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* sv/i2c_register_transaction_sequencer.sv */
// Top level of the I2C register transaction sequencer.
//
//   channel   direction   handshake              payload
//   request   in          in_valid / in_ready    in_data  (req_item_t)
//   result    out         out_valid / out_ready  out_data (res_item_t)
//
// Every request gives exactly one result; one request can be taken in every
// cycle when the result side is not stalled. A request passes the input
// register, then the combinational step logic, whose state updates when a
// request moves on, and then the result register.
// A stalled result holds the core; the input register still takes one more
// transfer. Synchronous reset returns the sequencer to idle with empty stages.
module i2c_register_transaction_sequencer #(
  parameter logic [7:0] MaxReadBytes = i2crts_pkg::MaxReadBytes
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2crts_pkg::req_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2crts_pkg::res_item_t out_data
);

  logic                  held_valid;
  i2crts_pkg::req_item_t held_item;
  i2crts_pkg::res_item_t res;
  logic                  can_load;
  logic                  fire;

  assign fire = held_valid && can_load;

  i2crts_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  i2crts_core #(
    .MaxReadBytes (MaxReadBytes)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .res  (res)
  );

  i2crts_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
